@@ design/vnfr_pkg.sv @@
package vnfr_pkg;

    typedef logic [31:0]        fp32_t;
    typedef logic signed [9:0]  fexp_t;

    localparam fp32_t MAGIC_RSQRT = 32'h5f37_59df;
    localparam fp32_t ONE_HALF    = 32'h3F00_0000;
    localparam fp32_t THREE_HALF  = 32'h3FC0_0000;
    localparam fp32_t DEFAULT_NAN = 32'h7FC0_0000;
    localparam fp32_t QUIET_BIT   = 32'h0040_0000;
    localparam fp32_t SIGN_BIT    = 32'h8000_0000;

    // register stages per unit and along the whole datapath
    localparam int MUL_LAT  = 2;
    localparam int ADD_LAT  = 3;
    localparam int PIPE_LAT = 6 * MUL_LAT + 3 * ADD_LAT;

    // denormals to signed zero
    function automatic fp32_t flush_sub(input fp32_t a);
        fp32_t r;
        r = (a[30:23] == 8'd0) ? (a & SIGN_BIT) : a;
        return r;
    endfunction

    function automatic logic is_nan(input fp32_t a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input fp32_t a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input fp32_t a);
        return a[30:23] == 8'd0;
    endfunction

    // RNE, overflow to inf, tiny results to signed zero
    function automatic fp32_t round_pack(input logic sgn, input fexp_t e,
                                         input logic [23:0] m, input logic g,
                                         input logic st);
        logic        inc;
        logic [24:0] mr;
        fexp_t       ef;
        fp32_t       r;
        inc = g & (st | m[0]);
        mr  = {1'b0, m} + 25'(inc);
        ef  = mr[24] ? (e + 10'sd1) : e;
        if (ef >= 10'sd255)
            r = {sgn, 8'hFF, 23'd0};
        else if (ef <= 10'sd0)
            r = {sgn, 31'd0};
        else
            r = {sgn, ef[7:0], (mr[24] ? 23'd0 : mr[22:0])};
        return r;
    endfunction

endpackage

@@ design/vnfr_if.sv @@
interface vnfr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vnfr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

@@ design/vnfr_delay.sv @@
module vnfr_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

@@ design/vnfr_fmul.sv @@
module vnfr_fmul (
    input  logic                clk,
    input  logic                en,
    input  vnfr_pkg::fp32_t     a,
    input  vnfr_pkg::fp32_t     b,
    output vnfr_pkg::fp32_t     y
);
    import vnfr_pkg::*;

    fp32_t       fa, fb;
    logic        spec_next;
    fp32_t       spec_val_next;
    logic        sgn_next;
    fexp_t       exp_next;
    logic [47:0] prod_next;

    logic        spec_reg;
    fp32_t       spec_val_reg;
    logic        sgn_reg;
    fexp_t       exp_reg;
    logic [47:0] prod_reg;

    logic [23:0] m;
    logic        g, st;
    fexp_t       e;
    fp32_t       y_next;
    fp32_t       y_reg;

    // stage 1: specials and 24x24 mantissa product
    always_comb
    begin
        fa            = flush_sub(a);
        fb            = flush_sub(b);
        sgn_next      = fa[31] ^ fb[31];
        spec_next     = 1'b1;
        spec_val_next = {sgn_next, 31'd0};
        priority if (is_nan(fa))
            spec_val_next = fa | QUIET_BIT;
        else if (is_nan(fb))
            spec_val_next = fb | QUIET_BIT;
        else if ((is_inf(fa) && is_zero(fb)) || (is_zero(fa) && is_inf(fb)))
            spec_val_next = DEFAULT_NAN;
        else if (is_inf(fa) || is_inf(fb))
            spec_val_next = {sgn_next, 8'hFF, 23'd0};
        else if (is_zero(fa) || is_zero(fb))
            spec_val_next = {sgn_next, 31'd0};
        else
            spec_next = 1'b0;
        exp_next  = fexp_t'({2'b00, fa[30:23]}) + fexp_t'({2'b00, fb[30:23]}) - 10'sd127;
        prod_next = {1'b1, fa[22:0]} * {1'b1, fb[22:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec_reg     <= spec_next;
            spec_val_reg <= spec_val_next;
            sgn_reg      <= sgn_next;
            exp_reg      <= exp_next;
            prod_reg     <= prod_next;
        end
    end

    // stage 2: normalise and round
    always_comb
    begin
        if (prod_reg[47])
        begin
            m  = prod_reg[47:24];
            g  = prod_reg[23];
            st = |prod_reg[22:0];
            e  = exp_reg + 10'sd1;
        end
        else
        begin
            m  = prod_reg[46:23];
            g  = prod_reg[22];
            st = |prod_reg[21:0];
            e  = exp_reg;
        end
        if (spec_reg)
            y_next = spec_val_reg;
        else if (e == 10'sd0)
            // below smallest normal: all-ones m rounds up to it, else signed zero
            y_next = (m == 24'hFF_FFFF) ? {sgn_reg, 8'h01, 23'd0} : {sgn_reg, 31'd0};
        else
            y_next = round_pack(sgn_reg, e, m, g, st);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;
endmodule

@@ design/vnfr_fadd.sv @@
module vnfr_fadd (
    input  logic                clk,
    input  logic                en,
    input  logic                sub,
    input  vnfr_pkg::fp32_t     a,
    input  vnfr_pkg::fp32_t     b,
    output vnfr_pkg::fp32_t     y
);
    import vnfr_pkg::*;

    fp32_t       fa, fb, fbn, big, sml;
    logic [7:0]  d;
    logic [26:0] m_sml, sh, lost_mask;
    logic        spec1_next, eff_sub1_next;
    fp32_t       spec_val1_next;
    logic [26:0] big1_next, al1_next;

    logic        spec1_reg, eff_sub1_reg, sgn1_reg;
    fp32_t       spec_val1_reg;
    fexp_t       exp1_reg;
    logic [26:0] big1_reg, al1_reg;

    logic [27:0] sum_next;
    logic [4:0]  lz_next;

    logic        spec2_reg, sgn2_reg;
    fp32_t       spec_val2_reg;
    fexp_t       exp2_reg;
    logic [27:0] sum2_reg;
    logic [4:0]  lz2_reg;

    logic [26:0] norm;
    logic [23:0] m;
    logic        g, st;
    fexp_t       e;
    fp32_t       y_next, y_reg;

    // stage 1: specials, order operands by magnitude, align the smaller
    always_comb
    begin
        fa             = flush_sub(a);
        fb             = flush_sub(b);
        fbn            = {fb[31] ^ sub, fb[30:0]};
        spec1_next     = 1'b1;
        spec_val1_next = fa;
        priority if (is_nan(fa))
            spec_val1_next = fa | QUIET_BIT;
        else if (is_nan(fb))
            spec_val1_next = fb | QUIET_BIT;
        else if (is_inf(fa) && is_inf(fbn) && (fa[31] != fbn[31]))
            spec_val1_next = DEFAULT_NAN;
        else if (is_inf(fa))
            spec_val1_next = fa;
        else if (is_inf(fbn))
            spec_val1_next = fbn;
        else if (is_zero(fa) && is_zero(fbn))
            spec_val1_next = {fa[31] & fbn[31], 31'd0};
        else if (is_zero(fa))
            spec_val1_next = fbn;
        else if (is_zero(fbn))
            spec_val1_next = fa;
        else
            spec1_next = 1'b0;

        if (fbn[30:0] > fa[30:0])
        begin
            big = fbn;
            sml = fa;
        end
        else
        begin
            big = fa;
            sml = fbn;
        end
        d             = big[30:23] - sml[30:23];
        m_sml         = {1'b1, sml[22:0], 3'b000};
        big1_next     = {1'b1, big[22:0], 3'b000};
        eff_sub1_next = big[31] ^ sml[31];
        sh            = '0;
        lost_mask     = '0;
        if (d >= 8'd27)
        begin
            al1_next = 27'd1;
        end
        else
        begin
            sh        = m_sml >> d;
            lost_mask = (27'd1 << d) - 27'd1;
            al1_next  = {sh[26:1], sh[0] | (|(m_sml & lost_mask))};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec1_reg     <= spec1_next;
            spec_val1_reg <= spec_val1_next;
            eff_sub1_reg  <= eff_sub1_next;
            sgn1_reg      <= big[31];
            exp1_reg      <= fexp_t'({2'b00, big[30:23]});
            big1_reg      <= big1_next;
            al1_reg       <= al1_next;
        end
    end

    // stage 2: add or subtract, count leading zeros
    always_comb
    begin
        sum_next = eff_sub1_reg ? ({1'b0, big1_reg} - {1'b0, al1_reg})
                                : ({1'b0, big1_reg} + {1'b0, al1_reg});
        lz_next  = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (sum_next[i])
                lz_next = 5'(26 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec2_reg     <= spec1_reg;
            spec_val2_reg <= spec_val1_reg;
            sgn2_reg      <= sgn1_reg;
            exp2_reg      <= exp1_reg;
            sum2_reg      <= sum_next;
            lz2_reg       <= lz_next;
        end
    end

    // stage 3: normalise and round
    always_comb
    begin
        norm = sum2_reg[26:0] << lz2_reg;
        if (sum2_reg[27])
        begin
            m  = sum2_reg[27:4];
            g  = sum2_reg[3];
            st = |sum2_reg[2:0];
            e  = exp2_reg + 10'sd1;
        end
        else
        begin
            m  = norm[26:3];
            g  = norm[2];
            st = |norm[1:0];
            e  = exp2_reg - fexp_t'({5'd0, lz2_reg});
        end
        if (spec2_reg)
            y_next = spec_val2_reg;
        else if (sum2_reg == 28'd0)
            y_next = 32'd0;
        else
            y_next = round_pack(sgn2_reg, e, m, g, st);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;
endmodule

@@ design/vec3_normalize_fast_rsqrt_unit.sv @@
// Channel   | Modport        | Payload                 | Handshake
// ----------+----------------+-------------------------+-------------
// vec_in    | vnfr_in_if.sink    | in_x, in_y, in_z (fp32) | valid/ready
// vec_out   | vnfr_out_if.source | out_x, out_y, out_z     | valid/ready
//
// One vector per cycle sustained while the output is not stalled; the path
// from acceptance to out valid runs through six multiplies of 2 stages and three adds of 3 stages in series.
// Reset clears only the valid bits; data registers carry no reset.
// A stall at the output freezes the whole pipe; vec_in.ready is low only
// while a finished result waits and is not taken.
module vec3_normalize_fast_rsqrt_unit (
    input  logic              clk,
    input  logic              rst_n,
    vnfr_in_if.sink           vec_in,
    vnfr_out_if.source        vec_out
);
    import vnfr_pkg::*;

    logic          en;
    logic [PIPE_LAT-1:0] vld_reg;

    fp32_t xx, yy, zz, zz_d, sxy, s, half_s, est;
    fp32_t est_d1, est_d2, est_d3, u, t, dif, r;
    logic [95:0] xyz_d;

    // pipe advances unless the output register holds an untaken result
    assign en           = !vld_reg[PIPE_LAT-1] || vec_out.ready;
    assign vec_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], vec_in.valid};
    end

    // squares
    vnfr_fmul u_mul_xx (.clk(clk), .en(en), .a(vec_in.in_x), .b(vec_in.in_x), .y(xx));
    vnfr_fmul u_mul_yy (.clk(clk), .en(en), .a(vec_in.in_y), .b(vec_in.in_y), .y(yy));
    vnfr_fmul u_mul_zz (.clk(clk), .en(en), .a(vec_in.in_z), .b(vec_in.in_z), .y(zz));

    vnfr_delay #(.WIDTH(32), .DEPTH(ADD_LAT)) u_dly_zz (.clk(clk), .en(en), .d(zz), .q(zz_d));

    // squared length, left-to-right
    vnfr_fadd u_add_xy (.clk(clk), .en(en), .sub(1'b0), .a(xx), .b(yy), .y(sxy));
    vnfr_fadd u_add_z  (.clk(clk), .en(en), .sub(1'b0), .a(sxy), .b(zz_d), .y(s));

    // integer estimate: arithmetic shift of the raw pattern, wrapping subtract
    assign est = MAGIC_RSQRT - ((s >> 1) | (s & SIGN_BIT));

    vnfr_fmul u_mul_half (.clk(clk), .en(en), .a(s), .b(ONE_HALF), .y(half_s));

    vnfr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_est1
        (.clk(clk), .en(en), .d(est), .q(est_d1));
    vnfr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_est2
        (.clk(clk), .en(en), .d(est_d1), .q(est_d2));
    vnfr_delay #(.WIDTH(32), .DEPTH(MUL_LAT + ADD_LAT)) u_dly_est3
        (.clk(clk), .en(en), .d(est_d2), .q(est_d3));

    // Newton step: r = est * (1.5 - ((0.5*s)*est)*est)
    vnfr_fmul u_mul_u (.clk(clk), .en(en), .a(half_s), .b(est_d1), .y(u));
    vnfr_fmul u_mul_t (.clk(clk), .en(en), .a(u), .b(est_d2), .y(t));
    vnfr_fadd u_sub_d (.clk(clk), .en(en), .sub(1'b1), .a(THREE_HALF), .b(t), .y(dif));
    vnfr_fmul u_mul_r (.clk(clk), .en(en), .a(est_d3), .b(dif), .y(r));

    // components wait for r
    vnfr_delay #(.WIDTH(96), .DEPTH(PIPE_LAT - MUL_LAT)) u_dly_xyz
        (.clk(clk), .en(en), .d({vec_in.in_x, vec_in.in_y, vec_in.in_z}), .q(xyz_d));

    // final scale; these unit registers are the output register
    vnfr_fmul u_mul_ox (.clk(clk), .en(en), .a(xyz_d[95:64]), .b(r), .y(vec_out.out_x));
    vnfr_fmul u_mul_oy (.clk(clk), .en(en), .a(xyz_d[63:32]), .b(r), .y(vec_out.out_y));
    vnfr_fmul u_mul_oz (.clk(clk), .en(en), .a(xyz_d[31:0]),  .b(r), .y(vec_out.out_z));

    assign vec_out.valid = vld_reg[PIPE_LAT-1];
endmodule

@@ design/vnfr_checker.sv @@
module vnfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z
);
    import vnfr_pkg::*;

    logic [5:0] outstanding_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else if (in_acc && !out_acc)
            outstanding_reg <= outstanding_reg + 6'd1;
        else if (out_acc && !in_acc)
            outstanding_reg <= outstanding_reg - 6'd1;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z))
        else $error("result changed while stalled");

    // backpressure only from a waiting result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // transactions in flight bounded by pipe depth
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 6'(PIPE_LAT))
        else $error("too many transactions in flight");

    // no result without an earlier input
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 6'd0)
        else $error("result with nothing outstanding");
endmodule

bind vec3_normalize_fast_rsqrt_unit vnfr_checker u_vnfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_in.valid),
    .in_ready  (vec_in.ready),
    .out_valid (vec_out.valid),
    .out_ready (vec_out.ready),
    .out_x     (vec_out.out_x),
    .out_y     (vec_out.out_y),
    .out_z     (vec_out.out_z)
);
